[rtl/core/tlca_pkg.sv]
// Package for the binary-lifting lowest common ancestor block.
// Holds sizes, microcode types and the microcode table itself.
// No dependencies.
package tlca_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 1 << NODE_W;
  localparam int LEVELS    = 10;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_DEPTH = MAX_NODES * (1 << LVL_W);
  localparam int DEPTH_W   = 10;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic [LVL_W-1:0]   LVL_TOP   = LVL_W'(LEVELS - 1);

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE    = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_LD_RDEP = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_LD_WDEP = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_LD_FILL = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_Q_RDEP  = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_Q_DIFF  = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_Q_PRIME = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_Q_LIFT  = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_Q_CHK   = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_Q_JUMP  = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_Q_FIN   = STEP_W'(10);

  typedef enum logic [3:0] {
    UOP_IDLE,
    UOP_LD_RDEP,
    UOP_LD_WDEP,
    UOP_LD_FILL,
    UOP_Q_RDEP,
    UOP_Q_DIFF,
    UOP_Q_PRIME,
    UOP_Q_LIFT,
    UOP_Q_CHK,
    UOP_Q_JUMP,
    UOP_Q_FIN
  } uop_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_DISPATCH,
    COND_LVL_TOP,
    COND_LVL_NOT_TOP,
    COND_LVL_NOT_ZERO,
    COND_NODES_EQ,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e               op;
    cond_e              cond;
    logic [STEP_W-1:0]  target;
    logic               last;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic is_query;
    logic node_zero;
    logic lvl_top;
    logic lvl_zero;
    logic nodes_eq;
    logic out_busy;
  } seq_flags_t;

  // A taken condition jumps to the target; otherwise the last step of a
  // routine returns to idle and any other step falls through.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      STEP_LD_RDEP: w = '{op: UOP_LD_RDEP, cond: COND_NONE,
                          target: STEP_IDLE, last: 1'b0};
      STEP_LD_WDEP: w = '{op: UOP_LD_WDEP, cond: COND_LVL_TOP,
                          target: STEP_IDLE, last: 1'b0};
      STEP_LD_FILL: w = '{op: UOP_LD_FILL, cond: COND_LVL_NOT_TOP,
                          target: STEP_LD_FILL, last: 1'b1};
      STEP_Q_RDEP:  w = '{op: UOP_Q_RDEP, cond: COND_NONE,
                          target: STEP_IDLE, last: 1'b0};
      STEP_Q_DIFF:  w = '{op: UOP_Q_DIFF, cond: COND_NONE,
                          target: STEP_IDLE, last: 1'b0};
      STEP_Q_PRIME: w = '{op: UOP_Q_PRIME, cond: COND_NONE,
                          target: STEP_IDLE, last: 1'b0};
      STEP_Q_LIFT:  w = '{op: UOP_Q_LIFT, cond: COND_LVL_NOT_ZERO,
                          target: STEP_Q_LIFT, last: 1'b0};
      STEP_Q_CHK:   w = '{op: UOP_Q_CHK, cond: COND_NODES_EQ,
                          target: STEP_Q_FIN, last: 1'b0};
      STEP_Q_JUMP:  w = '{op: UOP_Q_JUMP, cond: COND_LVL_NOT_ZERO,
                          target: STEP_Q_JUMP, last: 1'b0};
      STEP_Q_FIN:   w = '{op: UOP_Q_FIN, cond: COND_OUT_BUSY,
                          target: STEP_Q_FIN, last: 1'b1};
      default:      w = '{op: UOP_IDLE, cond: COND_DISPATCH,
                          target: STEP_IDLE, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/tlca_if.sv]
// Handshake channels of the lowest common ancestor block.
// tlca_in_if carries load and query items, tlca_out_if carries results.
// Depends on tlca_pkg.
interface tlca_in_if import tlca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;

  modport source (output valid, action, first_node, second_node, input ready);
  modport sink   (input valid, action, first_node, second_node, output ready);
endinterface

interface tlca_out_if import tlca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor_node;

  modport source (output valid, ancestor_node, input ready);
  modport sink   (input valid, ancestor_node, output ready);
endinterface

[rtl/core/tlca_ram.sv]
// Generic RAM with one write port and two read ports, registered reads.
// No dependencies.
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[rtl/core/tlca_seq.sv]
// Microcode sequencer: step counter over the control table in tlca_pkg.
// Evaluates jump conditions from datapath flags. Depends on tlca_pkg.
module tlca_seq import tlca_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  seq_flags_t flags_i,
  output ucode_t     ctrl_o,
  output logic       idle_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              taken;

  assign ctrl_o = ucode_rom(step_q);
  assign idle_o = (ctrl_o.op == UOP_IDLE);

  always_comb begin
    case (ctrl_o.cond)
      COND_LVL_TOP:      taken = flags_i.lvl_top;
      COND_LVL_NOT_TOP:  taken = !flags_i.lvl_top;
      COND_LVL_NOT_ZERO: taken = !flags_i.lvl_zero;
      COND_NODES_EQ:     taken = flags_i.nodes_eq;
      COND_OUT_BUSY:     taken = flags_i.out_busy;
      default:           taken = 1'b0;
    endcase

    if (ctrl_o.cond == COND_DISPATCH) begin
      if (!flags_i.accept) begin
        step_d = STEP_IDLE;
      end else if (flags_i.is_query) begin
        step_d = STEP_Q_RDEP;
      end else if (flags_i.node_zero) begin
        step_d = STEP_IDLE;
      end else begin
        step_d = STEP_LD_RDEP;
      end
    end else if (taken) begin
      step_d = ctrl_o.target;
    end else if (ctrl_o.last) begin
      step_d = STEP_IDLE;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

[rtl/core/tree_lca_binary_lifting.sv]
// Top level of the binary-lifting lowest common ancestor block.
// Microcoded datapath over a depth RAM and an ancestor RAM.
// Depends on tlca_pkg, tlca_in_if, tlca_out_if, tlca_ram and tlca_seq.
//
//   channel   dir  payload                                 handshake
//   item_i    in   action, first_node, second_node         valid/ready
//   result_o  out  ancestor_node                           valid/ready
//
// One item is taken at a time; ready is high while the sequencer idles.
// A load writes one depth entry and one table write per level before the
// earliest next accept. A query lifts the deeper node, then jumps both
// nodes level by level, skipping the jumps when the lifted node already equals
// the other; each level is one RAM read. Reset clears control only; the tables
// hold nothing until loaded. A result waiting in the output register does not
// block the next item; only a second finished query stalls until the first is taken.
module tree_lca_binary_lifting import tlca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlca_in_if.sink     item_i,
  tlca_out_if.source  result_o
);

  ucode_t     ctrl;
  seq_flags_t flags;
  logic       idle;
  logic       accept;

  logic [NODE_W-1:0] u_q, u_d, v_q, v_d, cur_q, cur_d;
  logic              byp_q, byp_d, eq_q, eq_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d, lvl_next;
  logic [LEVELS-1:0] diff_q, diff_d;
  logic              out_valid_q, out_valid_d;
  logic [NODE_W-1:0] ancestor_q, ancestor_d;

  logic               dep_we;
  logic [DEPTH_W-1:0] dep_wdata, dep_rdata_a, dep_rdata_b;

  logic               anc_we;
  logic [LVL_W-1:0]   anc_wlvl, anc_ra_lvl, anc_rb_lvl;
  logic [NODE_W-1:0]  anc_wdata, anc_ra_node, anc_rb_node;
  logic [NODE_W-1:0]  anc_rdata_a, anc_rdata_b, anc_a, anc_b;

  logic signed [DEPTH_W:0] du, dv;
  logic                    swap;
  logic [DEPTH_W:0]        depth_gap;
  logic [NODE_W-1:0]       fill_val, lift_u, jump_u, jump_v;

  tlca_seq u_seq (
    .clk_i,
    .rst_ni,
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .idle_o  (idle)
  );

  tlca_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_depth_ram (
    .clk_i,
    .we_i      (dep_we),
    .waddr_i   (u_q),
    .wdata_i   (dep_wdata),
    .raddr_a_i (u_q),
    .rdata_a_o (dep_rdata_a),
    .raddr_b_i (v_q),
    .rdata_b_o (dep_rdata_b)
  );

  tlca_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
    .clk_i,
    .we_i      (anc_we),
    .waddr_i   ({u_q, anc_wlvl}),
    .wdata_i   (anc_wdata),
    .raddr_a_i ({anc_ra_node, anc_ra_lvl}),
    .rdata_a_o (anc_rdata_a),
    .raddr_b_i ({anc_rb_node, anc_rb_lvl}),
    .rdata_b_o (anc_rdata_b)
  );

  assign item_i.ready = idle;
  assign accept       = item_i.valid && idle;

  assign result_o.valid         = out_valid_q;
  assign result_o.ancestor_node = ancestor_q;

  assign flags.accept    = accept;
  assign flags.is_query  = item_i.action;
  assign flags.node_zero = (item_i.first_node == '0);
  assign flags.lvl_top   = (lvl_q == LVL_TOP);
  assign flags.lvl_zero  = (lvl_q == '0);
  assign flags.nodes_eq  = (u_q == v_q);
  assign flags.out_busy  = out_valid_q && !result_o.ready;

  // Node 0 is the sentinel: depth minus one and no ancestors.
  assign anc_a     = (u_q == '0) ? '0 : anc_rdata_a;
  assign anc_b     = (v_q == '0) ? '0 : anc_rdata_b;
  assign du        = (u_q == '0) ? '1 : {1'b0, dep_rdata_a};
  assign dv        = (v_q == '0) ? '1 : {1'b0, dep_rdata_b};
  assign swap      = (du < dv);
  assign depth_gap = swap ? (dv - du) : (du - dv);

  assign dep_wdata = (v_q == '0) ? '0 :
                     (dep_rdata_b == DEPTH_MAX) ? DEPTH_MAX : dep_rdata_b + 1'b1;

  // The entry written last cycle is read back through cur_q when the
  // ancestor chain loops onto the node being loaded.
  assign fill_val = (cur_q == '0) ? '0 : (byp_q ? cur_q : anc_rdata_a);
  assign lift_u   = diff_q[lvl_q] ? anc_a : u_q;
  assign jump_u   = (anc_a != anc_b) ? anc_a : u_q;
  assign jump_v   = (anc_a != anc_b) ? anc_b : v_q;
  assign lvl_next = flags.lvl_zero ? '0 : lvl_q - 1'b1;

  always_comb begin
    u_d         = u_q;
    v_d         = v_q;
    cur_d       = cur_q;
    byp_d       = byp_q;
    eq_d        = eq_q;
    lvl_d       = lvl_q;
    diff_d      = diff_q;
    dep_we      = 1'b0;
    anc_we      = 1'b0;
    anc_wlvl    = lvl_q;
    anc_wdata   = fill_val;
    anc_ra_node = u_q;
    anc_ra_lvl  = lvl_q;
    anc_rb_node = v_q;
    anc_rb_lvl  = lvl_q;

    if (accept) begin
      u_d   = item_i.first_node;
      v_d   = item_i.second_node;
      lvl_d = '0;
    end

    case (ctrl.op)
      UOP_LD_WDEP: begin
        dep_we      = 1'b1;
        anc_we      = 1'b1;
        anc_wlvl    = '0;
        anc_wdata   = v_q;
        cur_d       = v_q;
        byp_d       = (v_q == u_q);
        anc_ra_node = v_q;
        anc_ra_lvl  = '0;
        if (!flags.lvl_top) begin
          lvl_d = lvl_q + 1'b1;
        end
      end
      UOP_LD_FILL: begin
        anc_we      = 1'b1;
        cur_d       = fill_val;
        byp_d       = (fill_val == u_q);
        anc_ra_node = fill_val;
        if (!flags.lvl_top) begin
          lvl_d = lvl_q + 1'b1;
        end
      end
      UOP_Q_DIFF: begin
        if (swap) begin
          u_d = v_q;
          v_d = u_q;
        end
        diff_d = LEVELS'(depth_gap);
      end
      UOP_Q_PRIME: begin
        anc_ra_lvl = LVL_TOP;
        lvl_d      = LVL_TOP;
      end
      UOP_Q_LIFT: begin
        u_d         = lift_u;
        anc_ra_node = lift_u;
        anc_ra_lvl  = lvl_next;
        lvl_d       = lvl_next;
      end
      UOP_Q_CHK: begin
        eq_d       = flags.nodes_eq;
        anc_ra_lvl = LVL_TOP;
        anc_rb_lvl = LVL_TOP;
        lvl_d      = LVL_TOP;
      end
      UOP_Q_JUMP: begin
        u_d         = jump_u;
        v_d         = jump_v;
        anc_ra_node = jump_u;
        anc_rb_node = jump_v;
        anc_ra_lvl  = lvl_next;
        anc_rb_lvl  = lvl_next;
        lvl_d       = lvl_next;
      end
      UOP_Q_FIN: begin
        anc_ra_lvl = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    ancestor_d  = ancestor_q;
    if (ctrl.op == UOP_Q_FIN && !flags.out_busy) begin
      out_valid_d = 1'b1;
      ancestor_d  = eq_q ? u_q : anc_a;
    end else if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lvl_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      lvl_q       <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q        <= u_d;
    v_q        <= v_d;
    cur_q      <= cur_d;
    byp_q      <= byp_d;
    eq_q       <= eq_d;
    diff_q     <= diff_d;
    ancestor_q <= ancestor_d;
  end

  a_fin_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == UOP_Q_FIN && !flags.out_busy) |=> out_valid_q
  ) else $error("finished query did not reach the output register");

  a_no_sentinel_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    dep_we |-> (u_q != '0)
  ) else $error("load wrote a table entry for the sentinel node");

  a_level_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == UOP_LD_FILL || ctrl.op == UOP_Q_LIFT || ctrl.op == UOP_Q_JUMP)
      |-> (lvl_q <= LVL_TOP)
  ) else $error("lifting level out of range");

  a_idle_after_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == UOP_Q_FIN && !flags.out_busy) |=> idle
  ) else $error("sequencer did not return to idle after a result");

endmodule
